[hdl/dtt_pkg.sv]
// Shared types and constants of the detection track table.
// No dependencies; imported by detection_track_table.
package dtt_pkg;

	localparam int TABLE_SLOTS = 16;
	localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int MAX_OUT     = 16;
	localparam int NOUT_W      = $clog2(MAX_OUT + 1);
	localparam int NEAR_MM     = 10;

	localparam int IN_DATA_W   = 80;
	localparam int OUT_DATA_W  = 104;

	// action codes
	localparam logic [2:0] ACT_DETECT = 3'd0;
	localparam logic [2:0] ACT_FRAME  = 3'd1;
	localparam logic [2:0] ACT_TICK   = 3'd2;
	localparam logic [2:0] ACT_QUERY  = 3'd3;
	localparam logic [2:0] ACT_CLEAR  = 3'd4;

	// register indexes
	localparam logic [1:0] REG_MIN_HITS    = 2'd0;
	localparam logic [1:0] REG_DROP_MISSES = 2'd1;
	localparam logic [1:0] REG_THRESHOLDS  = 2'd2;
	localparam logic [1:0] REG_ENABLE      = 2'd3;

	localparam logic [4:0] MISS_NEG_ONE = 5'h1f;

	typedef struct packed {
		logic [15:0]        id;
		logic [2:0]         cls;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic [3:0]         hits;
		logic [4:0]         misses;
	} entry_t;

	typedef enum logic [1:0] {
		P_DET,
		P_RET,
		P_LIST,
		P_QRY
	} pass_t;

endpackage

[hdl/detection_track_table.sv]
// Top level of the detection track table: sequencer, slot memory, output register.
// Depends on dtt_pkg.
//
// Detection track table. Keeps up to TABLE_SLOTS tracks (id, class, position,
// hit and miss counts) in a synchronous slot memory with a registered read;
// valid bits sit in flip-flops. Every request that touches the table walks all
// slots through the memory's single read port, each slot read, then evaluated:
//   detection (accepted)   : scan, then at most one write
//   end of frame           : retire pass, then list pass
//   timeout tick           : retire pass, then list pass only if it retired;
//                            no walk when a frame came since the previous tick
//   nearest query          : scan plus a squared-distance step per candidate slot
//   clear, paused, gated   : no walk (gated: not above threshold or x, y, z < NEAR_MM)
// A stalled result side holds the walk. A new request is taken only once the
// previous one is finished; a finished result may still wait in the output
// register meanwhile. Listing results carry kind 0, query answers kind 1; tlast
// marks the final result of a request. Configuration writes belong in idle
// periods only.
module detection_track_table (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [63:0]                        cfg_wdata,
	// request stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// object_id[15:0] class_id[18:16] confidence[26:19] pos_x[42:27]
	// pos_y[58:43] pos_z[74:59] filter_by_class[75] use_z[76], zero fill
	input  logic [dtt_pkg::IN_DATA_W-1:0]      s_tdata,
	// action[2:0]
	input  logic [2:0]                         s_tuser,
	// result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// found[0] track_id[16:1] track_x[32:17] track_y[48:33] track_z[64:49]
	// sqr_distance[98:65], zero fill
	output logic [dtt_pkg::OUT_DATA_W-1:0]     m_tdata,
	// kind[0]
	output logic                               m_tuser,
	output logic                               m_tlast
);
	import dtt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_EV,
		S_SQ,
		S_FIN
	} state_t;

	// configuration
	logic [3:0]  min_hits_q, drop_q;
	logic [63:0] thr_q;
	logic        en_q;

	// table state
	entry_t                 mem [TABLE_SLOTS];
	entry_t                 rd_q;
	logic [TABLE_SLOTS-1:0] valid_q;
	logic                   frame_seen_q;

	// sequencer
	state_t            st_q;
	pass_t             pass_q;
	logic [SLOT_W-1:0] cnt_q;
	logic              tick_q, any_q;

	// captured request
	logic [15:0]        id_q;
	logic [2:0]         cls_q;
	logic signed [15:0] x_q, y_q, z_q;
	logic               filt_q, usez_q;

	// detection match
	logic              hitf_q;
	logic [SLOT_W-1:0] hit_slot_q;
	logic [3:0]        hit_hits_q;
	logic [4:0]        hit_miss_q;

	// listing hold-back (lets the final entry carry tlast)
	logic              pend_v_q;
	entry_t            pend_q;
	logic [NOUT_W-1:0] n_q;

	// query
	logic [33:0] sqx_s1, sqy_s1, sqz_s1;
	entry_t      cand_s1;
	logic        bestf_q;
	logic [33:0] best_d_q;
	entry_t      best_q;

	// output register
	logic        out_v_q, out_kind_q, out_found_q, out_last_q;
	logic [15:0] out_id_q, out_x_q, out_y_q, out_z_q;
	logic [33:0] out_d_q;

	// input field views
	logic [15:0]        in_id;
	logic [2:0]         in_cls;
	logic [7:0]         in_conf;
	logic signed [15:0] in_x, in_y, in_z;
	assign in_id   = s_tdata[15:0];
	assign in_cls  = s_tdata[18:16];
	assign in_conf = s_tdata[26:19];
	assign in_x    = s_tdata[42:27];
	assign in_y    = s_tdata[58:43];
	assign in_z    = s_tdata[74:59];

	assign s_tready = (st_q == S_IDLE);

	logic s_acc;
	assign s_acc = s_tvalid && s_tready;

	logic out_ok;
	assign out_ok = !out_v_q || m_tready;

	logic [3:0] eff_min;
	assign eff_min = (min_hits_q == 4'd0) ? 4'd1 : min_hits_q;

	// detection gate: above class threshold and not with x, y and z all below NEAR_MM
	logic [7:0] thr_sel;
	logic       det_ok;
	assign thr_sel = thr_q[{in_cls, 3'b000} +: 8];
	assign det_ok  = (in_conf > thr_sel) &&
		!((in_x < 16'(NEAR_MM)) && (in_y < 16'(NEAR_MM)) && (in_z < 16'(NEAR_MM)));

	logic cur_valid, cur_conf;
	assign cur_valid = valid_q[cnt_q];
	assign cur_conf  = cur_valid && (rd_q.hits >= eff_min);

	logic last_slot;
	assign last_slot = (cnt_q == SLOT_W'(TABLE_SLOTS - 1));

	// retire arithmetic
	logic [4:0] miss_inc;
	logic       retire_now;
	assign miss_inc   = rd_q.misses + 5'd1;
	assign retire_now = $signed(miss_inc) >= $signed({1'b0, drop_q});

	// lowest free slot
	logic              free_any;
	logic [SLOT_W-1:0] free_slot;
	always_comb begin
		free_any  = 1'b0;
		free_slot = '0;
		for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any  = 1'b1;
				free_slot = SLOT_W'(i);
			end
		end
	end

	// updated hit entry
	logic [4:0] hit_inc;
	logic       hit_confirm;
	assign hit_inc     = {1'b0, hit_hits_q} + 5'd1;
	assign hit_confirm = hit_inc >= {1'b0, eff_min};

	// query distance terms
	logic signed [16:0] dx, dy, dz;
	logic signed [33:0] px, py, pz;
	logic [33:0]        dsum;
	assign dx   = 17'(x_q) - 17'(rd_q.x);
	assign dy   = 17'(y_q) - 17'(rd_q.y);
	assign dz   = 17'(z_q) - 17'(rd_q.z);
	assign px   = dx * dx;
	assign py   = dy * dy;
	assign pz   = dz * dz;
	assign dsum = sqx_s1 + sqy_s1 + sqz_s1;

	logic qry_cand;
	assign qry_cand = cur_conf && (!filt_q || (rd_q.cls == cls_q));

	// output register is loaded by the sequencer this cycle
	logic out_load;
	assign out_load = out_ok && (
		(st_q == S_EV && pass_q == P_LIST && cur_conf && n_q < NOUT_W'(MAX_OUT) &&
			pend_v_q) ||
		(st_q == S_FIN && pass_q == P_LIST && pend_v_q) ||
		(st_q == S_FIN && pass_q == P_QRY));

	// memory write port
	logic              we;
	logic [SLOT_W-1:0] waddr;
	entry_t            wdata;
	always_comb begin
		we    = 1'b0;
		waddr = cnt_q;
		wdata = rd_q;
		if (st_q == S_EV && pass_q == P_RET && cur_valid) begin
			we           = 1'b1;
			wdata.misses = miss_inc;
		end else if (st_q == S_FIN && pass_q == P_DET && (hitf_q || free_any)) begin
			we          = 1'b1;
			wdata.id    = id_q;
			wdata.cls   = cls_q;
			wdata.x     = x_q;
			wdata.y     = y_q;
			wdata.z     = z_q;
			if (hitf_q) begin
				waddr        = hit_slot_q;
				wdata.hits   = hit_confirm ? eff_min : hit_inc[3:0];
				wdata.misses = hit_confirm ? MISS_NEG_ONE : hit_miss_q;
			end else begin
				waddr        = free_slot;
				wdata.hits   = 4'd1;
				wdata.misses = MISS_NEG_ONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_q <= mem[cnt_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_hits_q   <= 4'd1;
			drop_q       <= 4'd3;
			thr_q        <= '1;
			en_q         <= 1'b1;
			valid_q      <= '0;
			frame_seen_q <= 1'b0;
			st_q         <= S_IDLE;
			pass_q       <= P_DET;
			cnt_q        <= '0;
			tick_q       <= 1'b0;
			any_q        <= 1'b0;
			id_q         <= '0;
			cls_q        <= '0;
			x_q          <= '0;
			y_q          <= '0;
			z_q          <= '0;
			filt_q       <= 1'b0;
			usez_q       <= 1'b0;
			hitf_q       <= 1'b0;
			hit_slot_q   <= '0;
			hit_hits_q   <= '0;
			hit_miss_q   <= '0;
			pend_v_q     <= 1'b0;
			pend_q       <= '0;
			n_q          <= '0;
			sqx_s1       <= '0;
			sqy_s1       <= '0;
			sqz_s1       <= '0;
			cand_s1      <= '0;
			bestf_q      <= 1'b0;
			best_d_q     <= '0;
			best_q       <= '0;
			out_v_q      <= 1'b0;
			out_kind_q   <= 1'b0;
			out_found_q  <= 1'b0;
			out_last_q   <= 1'b0;
			out_id_q     <= '0;
			out_x_q      <= '0;
			out_y_q      <= '0;
			out_z_q      <= '0;
			out_d_q      <= '0;
		end else begin
			if (m_tready && !out_load)
				out_v_q <= 1'b0;

			if (cfg_we) begin
				unique case (cfg_index)
					REG_MIN_HITS:    min_hits_q <= cfg_wdata[3:0];
					REG_DROP_MISSES: drop_q     <= cfg_wdata[3:0];
					REG_THRESHOLDS:  thr_q      <= cfg_wdata;
					REG_ENABLE:      en_q       <= cfg_wdata[0];
					default: ;
				endcase
			end

			unique case (st_q)
				S_IDLE: begin
					if (s_acc) begin
						id_q     <= in_id;
						cls_q    <= in_cls;
						x_q      <= in_x;
						y_q      <= in_y;
						z_q      <= in_z;
						filt_q   <= s_tdata[75];
						usez_q   <= s_tdata[76];
						cnt_q    <= '0;
						hitf_q   <= 1'b0;
						any_q    <= 1'b0;
						bestf_q  <= 1'b0;
						pend_v_q <= 1'b0;
						n_q      <= '0;
						case (s_tuser)
							ACT_DETECT: begin
								if (en_q && det_ok) begin
									pass_q <= P_DET;
									st_q   <= S_RD;
								end
							end
							ACT_FRAME: begin
								frame_seen_q <= 1'b1;
								if (en_q) begin
									pass_q <= P_RET;
									tick_q <= 1'b0;
									st_q   <= S_RD;
								end
							end
							ACT_TICK: begin
								if (en_q) begin
									frame_seen_q <= 1'b0;
									if (!frame_seen_q) begin
										pass_q <= P_RET;
										tick_q <= 1'b1;
										st_q   <= S_RD;
									end
								end
							end
							ACT_QUERY: begin
								pass_q <= P_QRY;
								st_q   <= S_RD;
							end
							ACT_CLEAR: begin
								valid_q      <= '0;
								frame_seen_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end

				S_RD: st_q <= S_EV;

				S_EV: begin
					// default: move to the next slot
					logic adv;
					adv = 1'b1;
					case (pass_q)
						P_DET: begin
							if (cur_valid && rd_q.id == id_q && !hitf_q) begin
								hitf_q     <= 1'b1;
								hit_slot_q <= cnt_q;
								hit_hits_q <= rd_q.hits;
								hit_miss_q <= rd_q.misses;
							end
						end
						P_RET: begin
							if (cur_valid && retire_now) begin
								valid_q[cnt_q] <= 1'b0;
								any_q          <= 1'b1;
							end
						end
						P_LIST: begin
							if (cur_conf && n_q < NOUT_W'(MAX_OUT)) begin
								if (pend_v_q && !out_ok) begin
									adv = 1'b0;
								end else begin
									if (pend_v_q) begin
										out_v_q     <= 1'b1;
										out_kind_q  <= 1'b0;
										out_found_q <= 1'b0;
										out_last_q  <= 1'b0;
										out_id_q    <= pend_q.id;
										out_x_q     <= pend_q.x;
										out_y_q     <= pend_q.y;
										out_z_q     <= pend_q.z;
										out_d_q     <= '0;
									end
									pend_v_q <= 1'b1;
									pend_q   <= rd_q;
									n_q      <= n_q + NOUT_W'(1);
								end
							end
						end
						P_QRY: begin
							if (qry_cand) begin
								sqx_s1  <= px;
								sqy_s1  <= py;
								sqz_s1  <= usez_q ? pz : 34'd0;
								cand_s1 <= rd_q;
								adv = 1'b0;
								st_q <= S_SQ;
							end
						end
						default: ;
					endcase
					if (adv) begin
						if (last_slot) begin
							st_q <= S_FIN;
						end else begin
							cnt_q <= cnt_q + SLOT_W'(1);
							st_q  <= S_RD;
						end
					end
				end

				S_SQ: begin
					if (!bestf_q || dsum < best_d_q) begin
						bestf_q  <= 1'b1;
						best_d_q <= dsum;
						best_q   <= cand_s1;
					end
					if (last_slot) begin
						st_q <= S_FIN;
					end else begin
						cnt_q <= cnt_q + SLOT_W'(1);
						st_q  <= S_RD;
					end
				end

				S_FIN: begin
					case (pass_q)
						P_DET: begin
							if (!hitf_q && free_any)
								valid_q[free_slot] <= 1'b1;
							st_q <= S_IDLE;
						end
						P_RET: begin
							if (tick_q && !any_q) begin
								st_q <= S_IDLE;
							end else begin
								pass_q   <= P_LIST;
								cnt_q    <= '0;
								pend_v_q <= 1'b0;
								n_q      <= '0;
								st_q     <= S_RD;
							end
						end
						P_LIST: begin
							if (!pend_v_q) begin
								st_q <= S_IDLE;
							end else if (out_ok) begin
								out_v_q     <= 1'b1;
								out_kind_q  <= 1'b0;
								out_found_q <= 1'b0;
								out_last_q  <= 1'b1;
								out_id_q    <= pend_q.id;
								out_x_q     <= pend_q.x;
								out_y_q     <= pend_q.y;
								out_z_q     <= pend_q.z;
								out_d_q     <= '0;
								pend_v_q    <= 1'b0;
								st_q        <= S_IDLE;
							end
						end
						P_QRY: begin
							if (out_ok) begin
								out_v_q     <= 1'b1;
								out_kind_q  <= 1'b1;
								out_found_q <= bestf_q;
								out_last_q  <= 1'b1;
								out_id_q    <= bestf_q ? best_q.id : 16'd0;
								out_x_q     <= bestf_q ? best_q.x : 16'd0;
								out_y_q     <= bestf_q ? best_q.y : 16'd0;
								out_z_q     <= bestf_q ? best_q.z : 16'd0;
								out_d_q     <= bestf_q ? best_d_q : 34'd0;
								st_q        <= S_IDLE;
							end
						end
						default: ;
					endcase
				end

				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {5'd0, out_d_q, out_z_q, out_y_q, out_x_q, out_id_q, out_found_q};

endmodule
